>>> rtl/csc_pkg.sv
// Package for the checked stack: operation kinds, status codes, register indexes,
// sequencer states and the request struct to the shared modulo unit. No dependencies.
package csc_pkg;
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_TOP  = 2'd2;
  localparam logic [1:0] KIND_NOP  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BADDEPTH = 3'd3;
  localparam logic [2:0] ST_POISON   = 3'd4;
  localparam logic [2:0] ST_CHECKSUM = 3'd5;

  localparam logic [1:0] REG_POISON = 2'd0;
  localparam logic [1:0] REG_MULT   = 2'd1;
  localparam logic [1:0] REG_MOD    = 2'd2;
  localparam logic [1:0] REG_CHECK  = 2'd3;

  localparam logic [31:0] SUM_START = 32'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SCAN_RD, S_SCAN_CMP, S_SUM_RD, S_SUM_MUL, S_SUM_ADD,
    S_ACT, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } mod_req_t;
endpackage

>>> rtl/csc_mod_unit.sv
// Serial 64-bit modulo unit, one quotient bit per cycle, used for every checksum
// reduction. Depends on csc_pkg.
module csc_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  csc_pkg::mod_req_t req,
  input  logic [31:0]       modulus,
  output logic              done,
  output logic [31:0]       result
);
  logic [63:0] dividend_r, dividend_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    dividend_nxt = dividend_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[31:0], dividend_r[63]};
    if (req.start) begin
      dividend_nxt = req.value;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (modulus == 32'd0) begin
        rem_nxt = {1'b0, dividend_r[31:0]};
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt = (trial >= {1'b0, modulus}) ? trial - {1'b0, modulus} : trial;
        dividend_nxt = {dividend_r[62:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dividend_r <= dividend_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign result = rem_r[31:0];

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("modulo done while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && modulus != 32'd0 && $stable(modulus)) |-> rem_r < {1'b0, modulus})
    else $error("remainder not reduced");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r || done_r) else $error("modulo start lost");
endmodule

>>> rtl/checked_stack_with_checksum.sv
// Top level of the checked stack: slot memory, sequencer and checksum recompute.
// Depends on csc_pkg and csc_mod_unit.
//
// Requests enter on in_* (tdata = kind, push_value); one result per request on out_*
// (tdata = top_value, status). The block takes one request at a time. A request other
// than a nop runs the checks (depth; and, while checking is on, a poison scan of every
// slot at or above the depth and a checksum recompute: one serial modulo step for the
// start value, then three per live entry), acts, and for push and pop recomputes the
// checksum again.
// After reset the block sweeps every slot to the poison value, with in_tready low. A
// result waits in the output register while out_tready is low and the next request is
// not taken until it has left. Configuration writes go through cfg_* at any time the
// block is idle; a poison write also sweeps the unused slots, with in_tready low.
module checked_stack_with_checksum #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // kind[1:0], push_value[33:2], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // top_value[31:0], status[34:32], zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic [31:0] slots_mem [STACK_DEPTH];
  logic [31:0] rd_data_r;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) slots_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= slots_mem[mem_raddr];
  end

  csc_pkg::state_t state_r, state_nxt;
  logic [31:0] poison_r, mult_r, mod_r;
  logic        check_r;
  logic [CW-1:0] depth_r, depth_nxt;
  logic [31:0] csum_r, csum_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] val_r, val_nxt;
  logic        after_r, after_nxt;
  logic [31:0] out_top_r, out_top_nxt;
  logic [2:0]  out_st_r, out_st_nxt;
  logic        step_r, step_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [63:0] prod_r;
  csc_pkg::mod_req_t mreq;
  logic        mdone;
  logic [31:0] mres;
  logic [31:0] dmask, pword;

  assign dmask = (DATA_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << DATA_WIDTH) - 64'd1);
  assign pword = poison_r & dmask;

  csc_mod_unit u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .modulus(mod_r),
                      .done(mdone), .result(mres));

  always_ff @(posedge clk) prod_r <= {32'd0, acc_r} * {32'd0, mult_r};

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    csum_nxt = csum_r;
    idx_nxt = idx_r;
    acc_nxt = acc_r;
    kind_nxt = kind_r;
    val_nxt = val_r;
    after_nxt = after_r;
    out_top_nxt = out_top_r;
    out_st_nxt = out_st_r;
    step_nxt = 1'b0;
    phase_nxt = phase_r;
    mreq = '0;
    mem_we = 1'b0;
    mem_waddr = idx_r[AW-1:0];
    mem_wdata = pword;
    mem_raddr = idx_r[AW-1:0];
    in_tready = 1'b0;
    case (state_r)
      csc_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == DEPTH_C - 1'b1) state_nxt = csc_pkg::S_IDLE;
      end
      csc_pkg::S_IDLE: begin
        in_tready = !out_tvalid && !(cfg_we && cfg_index == csc_pkg::REG_POISON);
        if (cfg_we && cfg_index == csc_pkg::REG_POISON) begin
          if (depth_r < DEPTH_C) begin
            idx_nxt = depth_r;
            state_nxt = csc_pkg::S_CLEAR;
          end
        end else if (in_tvalid && in_tready) begin
          kind_nxt = in_tdata[1:0];
          val_nxt = in_tdata[33:2] & dmask;
          out_top_nxt = pword;
          out_st_nxt = csc_pkg::ST_OK;
          after_nxt = 1'b0;
          if (in_tdata[1:0] == csc_pkg::KIND_NOP) state_nxt = csc_pkg::S_OUT;
          else if (check_r) begin
            idx_nxt = depth_r;
            state_nxt = (depth_r == DEPTH_C) ? csc_pkg::S_SUM_RD : csc_pkg::S_SCAN_RD;
            acc_nxt = SUM_START_C;
            phase_nxt = 2'd0;
          end else state_nxt = csc_pkg::S_ACT;
        end
      end
      csc_pkg::S_SCAN_RD: state_nxt = csc_pkg::S_SCAN_CMP;
      csc_pkg::S_SCAN_CMP: begin
        if (rd_data_r != pword) begin
          out_st_nxt = csc_pkg::ST_POISON;
          state_nxt = csc_pkg::S_OUT;
        end else if (idx_r == DEPTH_C - 1'b1) begin
          idx_nxt = '0;
          state_nxt = csc_pkg::S_SUM_RD;
          phase_nxt = 2'd0;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = csc_pkg::S_SCAN_RD;
        end
      end
      csc_pkg::S_SUM_RD: begin
        // phase 0: reduce start, then per entry multiply and add
        if (phase_r == 2'd0) begin
          mreq.start = 1'b1;
          mreq.value = {32'd0, csc_pkg::SUM_START};
          phase_nxt = 2'd1;
          idx_nxt = '0;
        end else if (mdone) begin
          acc_nxt = mres;
          if (idx_r == depth_r) begin
            if (after_r) begin
              csum_nxt = mres;
              state_nxt = csc_pkg::S_OUT;
            end else if (mres != csum_r) begin
              out_st_nxt = csc_pkg::ST_CHECKSUM;
              state_nxt = csc_pkg::S_OUT;
            end else state_nxt = csc_pkg::S_ACT;
          end else begin
            state_nxt = csc_pkg::S_SUM_MUL;
            step_nxt = 1'b1;
          end
        end
      end
      csc_pkg::S_SUM_MUL: begin
        if (step_r) ;
        else if (phase_r == 2'd1) begin
          mreq.start = 1'b1;
          mreq.value = prod_r;
          phase_nxt = 2'd2;
        end else if (phase_r == 2'd2 && mdone) begin
          acc_nxt = mres;
          mreq.start = 1'b1;
          mreq.value = {32'd0, rd_data_r};
          phase_nxt = 2'd3;
        end else if (phase_r == 2'd3 && mdone) begin
          mreq.start = 1'b1;
          mreq.value = {31'd0, {1'b0, acc_r} + {1'b0, mres}};
          phase_nxt = 2'd1;
          idx_nxt = idx_r + 1'b1;
          state_nxt = csc_pkg::S_SUM_RD;
        end
      end
      csc_pkg::S_ACT: begin
        state_nxt = csc_pkg::S_OUT;
        case (kind_r)
          csc_pkg::KIND_PUSH: begin
            if (depth_r >= DEPTH_C) out_st_nxt = csc_pkg::ST_FULL;
            else begin
              mem_we = 1'b1;
              mem_waddr = depth_r[AW-1:0];
              mem_wdata = val_r;
              depth_nxt = depth_r + 1'b1;
              after_nxt = 1'b1;
              phase_nxt = 2'd0;
              state_nxt = csc_pkg::S_SUM_RD;
            end
          end
          csc_pkg::KIND_POP: begin
            if (depth_r == '0) out_st_nxt = csc_pkg::ST_EMPTY;
            else begin
              mem_we = 1'b1;
              mem_waddr = AW'(depth_r - 1'b1);
              depth_nxt = depth_r - 1'b1;
              after_nxt = 1'b1;
              phase_nxt = 2'd0;
              state_nxt = csc_pkg::S_SUM_RD;
            end
          end
          csc_pkg::KIND_TOP: begin
            if (depth_r == '0) out_st_nxt = csc_pkg::ST_EMPTY;
            else begin
              idx_nxt = depth_r - 1'b1;
              state_nxt = csc_pkg::S_SCAN_RD;
              after_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      csc_pkg::S_OUT: begin
        if (kind_r == csc_pkg::KIND_TOP && after_r) out_top_nxt = rd_data_r;
        state_nxt = csc_pkg::S_IDLE;
      end
      default: state_nxt = csc_pkg::S_IDLE;
    endcase
    // top read reuses the scan read state; divert its compare
    if (state_r == csc_pkg::S_SCAN_CMP && kind_r == csc_pkg::KIND_TOP && after_r) begin
      out_top_nxt = rd_data_r;
      out_st_nxt = csc_pkg::ST_OK;
      after_nxt = 1'b0;
      state_nxt = csc_pkg::S_OUT;
    end
    // the memory read address for checksum entries follows idx
    if (state_r == csc_pkg::S_SUM_RD || state_r == csc_pkg::S_SUM_MUL)
      mem_raddr = idx_r[AW-1:0];
  end

  localparam logic [31:0] SUM_START_C = csc_pkg::SUM_START;

  logic out_v_r;
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    kind_r <= kind_nxt;
    val_r <= val_nxt;
    out_top_r <= out_top_nxt;
    out_st_r <= out_st_nxt;
    step_r <= step_nxt;
    phase_r <= phase_nxt;
    if (!rst_n) begin
      state_r <= csc_pkg::S_CLEAR;
      idx_r <= '0;
      depth_r <= '0;
      csum_r <= csc_pkg::SUM_START;
      poison_r <= '0;
      mult_r <= 32'd31;
      mod_r <= 32'd1000000007;
      check_r <= 1'b1;
      after_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      depth_r <= depth_nxt;
      csum_r <= csum_nxt;
      after_r <= (state_r == csc_pkg::S_OUT) ? 1'b0 : after_nxt;
      if (cfg_we) begin
        case (cfg_index)
          csc_pkg::REG_POISON: poison_r <= cfg_data;
          csc_pkg::REG_MULT:   mult_r <= cfg_data;
          csc_pkg::REG_MOD:    mod_r <= cfg_data;
          csc_pkg::REG_CHECK:  check_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (state_r == csc_pkg::S_OUT) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {5'd0, out_st_r, out_top_r};

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == csc_pkg::S_IDLE) else $error("ready outside idle");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_C) else $error("depth overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
endmodule
